// ----- sv/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define JPC_ASSERT_CR(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on aclk / aresetn
`define JPC_ASSERT(label, prop, msg) \
    `JPC_ASSERT_CR(label, aclk, aresetn, prop, msg)

`endif

// ----- sv/jpc_pkg.sv -----
// Shared constants, types and the sine table for the joystick polar converter.
package jpc_pkg;

    localparam int IN_W       = 12;
    localparam int AXIS_W     = 11;
    localparam int MAG_W      = 11;
    localparam int DIR_W      = 9;
    localparam int Q_W        = 11;
    localparam int DEN_W      = 13;
    localparam int SQ_W       = 22;
    localparam int ROOT_STEPS = 11;
    localparam int SRCH_LVL   = 7;
    localparam int IDX_W      = 7;
    localparam int ROM_W      = 44;
    localparam int ROM_LAST   = 90;
    localparam int ROM_SHIFT  = 16;
    localparam int PROD_W     = AXIS_W + ROM_W;

    localparam int OUT_SCALE  = 1024;
    localparam int ADC_FULL   = 4096;
    localparam int MAX_DEG    = 89;
    localparam int CENTER_RST = 2048;

    // Cycle counts of the units, register to register
    localparam int LAT_DIV   = Q_W + 2;
    localparam int LAT_SQRT  = ROOT_STEPS + 3;
    localparam int LAT_ANGLE = 2 * SRCH_LVL + 2;
    localparam int LAT_TOTAL = LAT_DIV + LAT_ANGLE;
    localparam int MAG_DLY   = LAT_ANGLE - LAT_SQRT;

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 48;

    // Configuration register indexes
    localparam logic REG_X_CENTER = 1'b0;
    localparam logic REG_Y_CENTER = 1'b1;

    // Quadrant base angles in degrees
    localparam logic [DIR_W-1:0] BASE_Q0 = 9'd0;
    localparam logic [DIR_W-1:0] BASE_Q1 = 9'd90;
    localparam logic [DIR_W-1:0] BASE_Q2 = 9'd180;
    localparam logic [DIR_W-1:0] BASE_Q3 = 9'd270;

    // sin and cos of one degree, scaled by 10^18
    localparam logic [127:0] E_SCALE  = 128'd1000000000000000000;
    localparam logic [127:0] SIN1_E18 = 128'd17452406437283512;
    localparam logic [127:0] COS1_E18 = 128'd999847695156391239;

    typedef logic [ROM_W-1:0] rom_t [0:ROM_LAST];

    // Build sin(k deg) for k = 0..90 by the angle-sum recurrence
    function automatic rom_t build_rom();
        rom_t rom;
        logic [127:0] s_prev;
        logic [127:0] s_cur;
        logic [127:0] s_new;
        s_prev = '0;
        s_cur  = SIN1_E18;
        rom[0] = '0;
        rom[1] = ROM_W'(s_cur >> ROM_SHIFT);
        for (int k = 2; k <= ROM_LAST; k++) begin
            s_new  = ((128'd2 * COS1_E18 * s_cur) / E_SCALE) - s_prev;
            s_prev = s_cur;
            s_cur  = s_new;
            rom[k] = ROM_W'(s_cur >> ROM_SHIFT);
        end
        return rom;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

endpackage

// ----- sv/jpc_div.sv -----
// Axis normalizer: center compare, pipelined restoring divider, sign and clamp.
module jpc_div import jpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [IN_W-1:0]          sample,
    input  logic [IN_W-1:0]          center,
    output logic signed [AXIS_W-1:0] axis
);

    logic [DEN_W-1:0] r_reg   [0:Q_W];
    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             neg_reg [0:Q_W];
    logic             zero_reg[0:Q_W];

    logic [DEN_W-1:0] r_next  [0:Q_W];
    logic [Q_W-1:0]   q_next  [0:Q_W];
    logic [DEN_W-1:0] rem     [0:Q_W-1];
    logic             ge      [0:Q_W-1];

    logic             above;
    logic [DEN_W-1:0] delta;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q_sat;
    logic [AXIS_W-1:0] axis_next;
    logic [AXIS_W-1:0] axis_reg;

    // Distance from center and the span on that side
    always_comb begin
        above = sample > center;
        delta = above ? DEN_W'(sample - center) : DEN_W'(center - sample);
        den   = above ? (DEN_W'(ADC_FULL) - DEN_W'(center)) : DEN_W'(center);
    end

    // One quotient bit per stage, most significant first
    always_comb begin
        r_next[0] = delta;
        q_next[0] = '0;
        for (int i = 0; i < Q_W; i++) begin
            ge[i]       = r_reg[i] >= den_reg[i];
            rem[i]      = ge[i] ? (r_reg[i] - den_reg[i]) : r_reg[i];
            r_next[i+1] = {rem[i][DEN_W-2:0], 1'b0};
            q_next[i+1] = {q_reg[i][Q_W-2:0], ge[i]};
        end
    end

    // Zero at center, clamp positive overshoot, negate below center
    always_comb begin
        q_sat = (q_reg[Q_W] > Q_W'(OUT_SCALE - 1)) ? Q_W'(OUT_SCALE - 1) : q_reg[Q_W];
        if (zero_reg[Q_W]) begin
            axis_next = '0;
        end else if (neg_reg[Q_W]) begin
            axis_next = AXIS_W'(-q_reg[Q_W]);
        end else begin
            axis_next = AXIS_W'(q_sat);
        end
    end

    // Advance the stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= r_next[0];
            q_reg[0]    <= q_next[0];
            den_reg[0]  <= den;
            neg_reg[0]  <= sample < center;
            zero_reg[0] <= sample == center;
            for (int i = 1; i <= Q_W; i++) begin
                r_reg[i]    <= r_next[i];
                q_reg[i]    <= q_next[i];
                den_reg[i]  <= den_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
            axis_reg <= axis_next;
        end
    end

    assign axis = signed'(axis_reg);

endmodule

// ----- sv/jpc_isqrt.sv -----
// Magnitude: squares, sum, pipelined bit-pair square root, saturation.
module jpc_isqrt import jpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [AXIS_W-1:0] x_axis,
    input  logic signed [AXIS_W-1:0] y_axis,
    output logic [MAG_W-1:0]         magnitude
);

    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic [SQ_W-1:0]   xsq_reg;
    logic [SQ_W-1:0]   ysq_reg;
    logic [SQ_W-1:0]   v_reg    [0:ROOT_STEPS];
    logic [SQ_W-1:0]   root_reg [0:ROOT_STEPS];
    logic [SQ_W-1:0]   v_next   [1:ROOT_STEPS];
    logic [SQ_W-1:0]   root_next[1:ROOT_STEPS];
    logic [SQ_W:0]     trial    [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   bitv     [0:ROOT_STEPS-1];
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;

    always_comb begin
        ax = x_axis[AXIS_W-1] ? AXIS_W'(-x_axis) : AXIS_W'(x_axis);
        ay = y_axis[AXIS_W-1] ? AXIS_W'(-y_axis) : AXIS_W'(y_axis);
    end

    // Each stage settles one root bit
    always_comb begin
        for (int i = 0; i < ROOT_STEPS; i++) begin
            bitv[i]  = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - i));
            trial[i] = {1'b0, root_reg[i]} + {1'b0, bitv[i]};
            if ({1'b0, v_reg[i]} >= trial[i]) begin
                v_next[i+1]    = SQ_W'({1'b0, v_reg[i]} - trial[i]);
                root_next[i+1] = (root_reg[i] >> 1) + bitv[i];
            end else begin
                v_next[i+1]    = v_reg[i];
                root_next[i+1] = root_reg[i] >> 1;
            end
        end
        mag_next = (root_reg[ROOT_STEPS] > SQ_W'(OUT_SCALE)) ? MAG_W'(OUT_SCALE)
                                                            : MAG_W'(root_reg[ROOT_STEPS]);
    end

    // Advance the stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            xsq_reg     <= ax * ax;
            ysq_reg     <= ay * ay;
            v_reg[0]    <= xsq_reg + ysq_reg;
            root_reg[0] <= '0;
            for (int i = 1; i <= ROOT_STEPS; i++) begin
                v_reg[i]    <= v_next[i];
                root_reg[i] <= root_next[i];
            end
            mag_reg <= mag_next;
        end
    end

    assign magnitude = mag_reg;

endmodule

// ----- sv/jpc_angle.sv -----
// Direction: quadrant fold, then a pipelined binary search over the sine table.
module jpc_angle import jpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [AXIS_W-1:0] x_axis,
    input  logic signed [AXIS_W-1:0] y_axis,
    output logic [DIR_W-1:0]         direction
);

    // Search stage state, index 0 is the folded vector
    logic [AXIS_W-1:0] u_reg   [0:SRCH_LVL];
    logic [AXIS_W-1:0] v_reg   [0:SRCH_LVL];
    logic [DIR_W-1:0]  base_reg[0:SRCH_LVL];
    logic              zero_reg[0:SRCH_LVL];
    logic [IDX_W-1:0]  ans_reg [0:SRCH_LVL];

    // Product stage state, one per search level
    logic [AXIS_W-1:0] mu_reg  [0:SRCH_LVL-1];
    logic [AXIS_W-1:0] mv_reg  [0:SRCH_LVL-1];
    logic [DIR_W-1:0]  mb_reg  [0:SRCH_LVL-1];
    logic              mz_reg  [0:SRCH_LVL-1];
    logic [IDX_W-1:0]  mans_reg[0:SRCH_LVL-1];
    logic [IDX_W-1:0]  mt_reg  [0:SRCH_LVL-1];
    logic              mtv_reg [0:SRCH_LVL-1];
    logic [PROD_W-1:0] pa_reg  [0:SRCH_LVL-1];
    logic [PROD_W-1:0] pb_reg  [0:SRCH_LVL-1];

    logic [IDX_W-1:0]  t      [0:SRCH_LVL-1];
    logic              tv     [0:SRCH_LVL-1];
    logic [IDX_W-1:0]  ia     [0:SRCH_LVL-1];
    logic [IDX_W-1:0]  ib     [0:SRCH_LVL-1];
    logic [IDX_W-1:0]  ans_next[1:SRCH_LVL];

    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic [AXIS_W-1:0] u0;
    logic [AXIS_W-1:0] v0;
    logic [DIR_W-1:0]  base0;
    logic              zero0;
    logic [DIR_W-1:0]  dir_reg;

    // Fold the vector into the first quadrant of its own base axis
    always_comb begin
        ax    = x_axis[AXIS_W-1] ? AXIS_W'(-x_axis) : AXIS_W'(x_axis);
        ay    = y_axis[AXIS_W-1] ? AXIS_W'(-y_axis) : AXIS_W'(y_axis);
        zero0 = (x_axis == '0) && (y_axis == '0);
        if (!x_axis[AXIS_W-1] && !y_axis[AXIS_W-1] && (y_axis != '0)) begin
            u0 = ay; v0 = ax; base0 = BASE_Q0;
        end else if (!x_axis[AXIS_W-1] && (x_axis != '0) && (y_axis[AXIS_W-1] || y_axis == '0)) begin
            u0 = ax; v0 = ay; base0 = BASE_Q1;
        end else if ((x_axis[AXIS_W-1] || x_axis == '0) && y_axis[AXIS_W-1]) begin
            u0 = ay; v0 = ax; base0 = BASE_Q2;
        end else begin
            u0 = ax; v0 = ay; base0 = BASE_Q3;
        end
    end

    // Trial degree for each level, and the compare that keeps it
    always_comb begin
        for (int l = 0; l < SRCH_LVL; l++) begin
            t[l]  = ans_reg[l] | (IDX_W'(1) << (SRCH_LVL - 1 - l));
            tv[l] = t[l] <= IDX_W'(MAX_DEG);
            ia[l] = tv[l] ? t[l] : IDX_W'(1);
            ib[l] = IDX_W'(ROM_LAST) - ia[l];
            ans_next[l+1] = (mtv_reg[l] && (pa_reg[l] >= pb_reg[l])) ? mt_reg[l] : mans_reg[l];
        end
    end

    // Advance the stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0]    <= u0;
            v_reg[0]    <= v0;
            base_reg[0] <= base0;
            zero_reg[0] <= zero0;
            ans_reg[0]  <= '0;
            for (int l = 0; l < SRCH_LVL; l++) begin
                mu_reg[l]   <= u_reg[l];
                mv_reg[l]   <= v_reg[l];
                mb_reg[l]   <= base_reg[l];
                mz_reg[l]   <= zero_reg[l];
                mans_reg[l] <= ans_reg[l];
                mt_reg[l]   <= t[l];
                mtv_reg[l]  <= tv[l];
                pa_reg[l]   <= PROD_W'(v_reg[l]) * PROD_W'(SIN_ROM[ib[l]]);
                pb_reg[l]   <= PROD_W'(u_reg[l]) * PROD_W'(SIN_ROM[ia[l]]);
                u_reg[l+1]    <= mu_reg[l];
                v_reg[l+1]    <= mv_reg[l];
                base_reg[l+1] <= mb_reg[l];
                zero_reg[l+1] <= mz_reg[l];
                ans_reg[l+1]  <= ans_next[l+1];
            end
            dir_reg <= zero_reg[SRCH_LVL] ? '0
                       : base_reg[SRCH_LVL] + DIR_W'(ans_reg[SRCH_LVL]);
        end
    end

    assign direction = dir_reg;

endmodule

// ----- sv/joystick_axis_polar_convert_top.sv -----
// Throughput: one item per cycle; the divider, root and table search are fully pipelined.
// A stall on the result side freezes every stage; no item is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets both centers to 2048.
// Top level of the joystick axis normalizer and polar converter.
module joystick_axis_polar_convert_top import jpc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // x_sample[11:0], y_sample[23:12]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,  // x_axis[10:0], y_axis[21:11],
                                             // magnitude[32:22], direction[41:33]
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [IN_W-1:0]        cfg_wr_data
);

    logic [IN_W-1:0]          x_center_reg;
    logic [IN_W-1:0]          y_center_reg;
    logic                     vld_reg [0:LAT_TOTAL-1];
    logic                     en;
    logic signed [AXIS_W-1:0] x_div;
    logic signed [AXIS_W-1:0] y_div;
    logic [MAG_W-1:0]         mag_raw;
    logic [DIR_W-1:0]         dir_out;
    logic [AXIS_W-1:0]        xd_reg [0:LAT_ANGLE-1];
    logic [AXIS_W-1:0]        yd_reg [0:LAT_ANGLE-1];
    logic [MAG_W-1:0]         md_reg [0:MAG_DLY-1];

    // Advance whenever the result register is free or being taken
    assign en       = !vld_reg[LAT_TOTAL-1] || m_tready;
    assign s_tready = en;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_center_reg <= IN_W'(CENTER_RST);
            y_center_reg <= IN_W'(CENTER_RST);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_X_CENTER: x_center_reg <= cfg_wr_data;
                REG_Y_CENTER: y_center_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT_TOTAL; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT_TOTAL; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    jpc_div u_div_x (
        .aclk   (aclk),
        .en     (en),
        .sample (s_tdata[IN_W-1:0]),
        .center (x_center_reg),
        .axis   (x_div)
    );

    jpc_div u_div_y (
        .aclk   (aclk),
        .en     (en),
        .sample (s_tdata[2*IN_W-1:IN_W]),
        .center (y_center_reg),
        .axis   (y_div)
    );

    jpc_isqrt u_isqrt (
        .aclk      (aclk),
        .en        (en),
        .x_axis    (x_div),
        .y_axis    (y_div),
        .magnitude (mag_raw)
    );

    jpc_angle u_angle (
        .aclk      (aclk),
        .en        (en),
        .x_axis    (x_div),
        .y_axis    (y_div),
        .direction (dir_out)
    );

    // Align axes and magnitude with the direction
    always_ff @(posedge aclk) begin
        if (en) begin
            xd_reg[0] <= x_div;
            yd_reg[0] <= y_div;
            for (int i = 1; i < LAT_ANGLE; i++) begin
                xd_reg[i] <= xd_reg[i-1];
                yd_reg[i] <= yd_reg[i-1];
            end
            md_reg[0] <= mag_raw;
            for (int i = 1; i < MAG_DLY; i++) md_reg[i] <= md_reg[i-1];
        end
    end

    assign m_tvalid = vld_reg[LAT_TOTAL-1];
    assign m_tdata  = {6'b0, dir_out, md_reg[MAG_DLY-1],
                       yd_reg[LAT_ANGLE-1], xd_reg[LAT_ANGLE-1]};

endmodule

// ----- sv/jpc_checker.sv -----
// Port-level checker for the joystick polar converter, bound to the top level.
`include "assert_macros.svh"

module jpc_checker import jpc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    `JPC_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `JPC_ASSERT(a_dir_range, m_tvalid |-> m_tdata[41:33] <= 9'd359, "direction above 359")
    `JPC_ASSERT(a_mag_range, m_tvalid |-> m_tdata[32:22] <= 11'd1024, "magnitude above full scale")
    `JPC_ASSERT(a_zero_vec, m_tvalid && m_tdata[21:0] == 22'd0 |-> m_tdata[41:22] == 20'd0, "zero vector gave nonzero polar")
    `JPC_ASSERT(a_ready_free, !m_tvalid |-> s_tready, "input blocked with empty output")

endmodule

bind joystick_axis_polar_convert_top jpc_checker u_jpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
